// ===== sv/hbld_pkg.sv =====
// ----------------------------------------------------------------------------
// hbld_pkg
// Word types and request codes shared by the tree builder files.
// ----------------------------------------------------------------------------
package hbld_pkg;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  symbol;
      logic [31:0] freq_value;
      logic [8:0]  node_index;
   } req_type;

   typedef struct packed {
      logic [31:0] node_freq;
      logic [7:0]  node_symbol;
      logic [8:0]  left_child;
      logic [8:0]  right_child;
      logic [8:0]  parent_node;
      logic        is_leaf;
      logic        has_parent;
      logic [8:0]  node_count;
      logic        tree_empty;
   } rsp_type;

endpackage

// ===== sv/hbld_ram.sv =====
// ----------------------------------------------------------------------------
// hbld_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hbld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/huffman_tree_builder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_builder_top
// Builds a code tree over a min-heap held in RAM and serves node reads.
// ----------------------------------------------------------------------------
// A load passes through S_RESP, and a read through S_READ and then S_RESP, before its
// result word is registered. A build reads and writes each symbol in S_SCAN_RD and
// S_SCAN_WR, then each sift-down level steps through S_SK_L, S_SK_R and S_SK_C and
// each sift-up level through S_RISE_CHK and S_RISE_CMP on the heap RAM port.
// One word is processed at a time. Synchronous reset clears the
// frequency table through per-entry valid bits and zeroes the node and heap counts.
module huffman_tree_builder_top
   import hbld_pkg::*;
#(
   parameter int SYMBOLS   = 256,
   parameter int NODE_POOL = 512,
   parameter int FREQ_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SAW = $clog2(SYMBOLS);
   localparam int SIW = $clog2(SYMBOLS);
   localparam int HW  = SIW + 1;
   localparam int IW  = $clog2(NODE_POOL);
   localparam int PW  = $clog2(NODE_POOL + 1);
   localparam int NW  = FREQ_BITS + 8 + 2 * IW;
   localparam int HWD = IW + FREQ_BITS;

   typedef enum logic [18:0] {
      S_IDLE     = 19'h00001,
      S_SCAN_RD  = 19'h00002,
      S_SCAN_WR  = 19'h00004,
      S_HY_LD    = 19'h00008,
      S_HY_X     = 19'h00010,
      S_SK_L     = 19'h00020,
      S_SK_R     = 19'h00040,
      S_SK_C     = 19'h00080,
      S_LOOP     = 19'h00100,
      S_POP_RD0  = 19'h00200,
      S_POP_RDL  = 19'h00400,
      S_POP_SET  = 19'h00800,
      S_MRG0     = 19'h01000,
      S_MRG1     = 19'h02000,
      S_MRG2     = 19'h04000,
      S_RISE_CHK = 19'h08000,
      S_RISE_CMP = 19'h10000,
      S_READ     = 19'h20000,
      S_RESP     = 19'h40000
   } state_type;

   state_type         state_ff, state_in;
   logic [SAW-1:0]    scan_ff, scan_in;
   logic [PW-1:0]     pool_count_ff, pool_count_in;
   logic [PW-1:0]     leaf_count_ff, leaf_count_in;
   logic [HW-1:0]     heap_count_ff, heap_count_in;
   logic [SIW-1:0]    hi_ff, hi_in;
   logic [SIW-1:0]    idx_ff, idx_in;
   logic [HWD-1:0]    x_ff, x_in;
   logic [HWD-1:0]    lw_ff, lw_in;
   logic [HWD-1:0]    top_ff, top_in;
   logic [HWD-1:0]    a_ff, a_in;
   logic              second_ff, second_in;
   logic              heapify_ff, heapify_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYMBOLS-1:0] fv_ff, fv_in;

   logic              freq_we;
   logic [SAW-1:0]    freq_waddr, freq_raddr;
   logic [FREQ_BITS-1:0] freq_wdata, freq_rdata;
   logic              node_we;
   logic [IW-1:0]     node_waddr, node_raddr;
   logic [NW-1:0]     node_wdata, node_rdata;
   logic              par_we;
   logic [IW-1:0]     par_waddr, par_raddr;
   logic [IW:0]       par_wdata, par_rdata;
   logic              heap_we;
   logic [SIW-1:0]    heap_waddr, heap_raddr;
   logic [HWD-1:0]    heap_wdata, heap_rdata;

   logic [SIW+1:0]    l_pos, r_pos, hc_ext;
   logic              l_ok, r_ok;
   logic [SIW-1:0]    p_pos;
   logic [FREQ_BITS-1:0] scan_f, best_f;
   logic              take;
   logic [PW-1:0]     n_next;
   logic [FREQ_BITS:0] sum_w;
   logic [FREQ_BITS-1:0] sum_s;
   logic [1:0]        sel;
   logic              sink_end;

   hbld_ram #(.WIDTH(FREQ_BITS), .DEPTH(SYMBOLS)) u_freq (
      .clock(clock), .wr_en(freq_we), .wr_addr(freq_waddr), .wr_data(freq_wdata),
      .rd_addr(freq_raddr), .rd_data(freq_rdata));

   hbld_ram #(.WIDTH(NW), .DEPTH(NODE_POOL)) u_node (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_addr(node_raddr), .rd_data(node_rdata));

   hbld_ram #(.WIDTH(IW + 1), .DEPTH(NODE_POOL)) u_parent (
      .clock(clock), .wr_en(par_we), .wr_addr(par_waddr), .wr_data(par_wdata),
      .rd_addr(par_raddr), .rd_data(par_rdata));

   hbld_ram #(.WIDTH(HWD), .DEPTH(SYMBOLS)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
      .rd_addr(heap_raddr), .rd_data(heap_rdata));

   assign l_pos  = (SIW+2)'({idx_ff, 1'b1});
   assign r_pos  = l_pos + (SIW+2)'(1);
   assign hc_ext = (SIW+2)'(heap_count_ff);
   assign l_ok   = l_pos < hc_ext;
   assign r_ok   = r_pos < hc_ext;
   assign p_pos  = (idx_ff - SIW'(1)) >> 1;
   assign scan_f = fv_ff[scan_ff] ? freq_rdata : '0;
   assign take   = (scan_f != '0) && (pool_count_ff < PW'(NODE_POOL));
   assign n_next = pool_count_ff + PW'(take);
   assign sum_w  = {1'b0, a_ff[FREQ_BITS-1:0]} + {1'b0, top_ff[FREQ_BITS-1:0]};
   assign sum_s  = sum_w[FREQ_BITS] ? '1 : sum_w[FREQ_BITS-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pool_count_in = pool_count_ff;
      leaf_count_in = leaf_count_ff;
      heap_count_in = heap_count_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      lw_in         = lw_ff;
      top_in        = top_ff;
      a_in          = a_ff;
      second_in     = second_ff;
      heapify_in    = heapify_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      fv_in         = fv_ff;
      freq_we       = 1'b0;
      freq_waddr    = req_data.symbol[SAW-1:0];
      freq_wdata    = FREQ_BITS'(req_data.freq_value);
      freq_raddr    = scan_ff;
      node_we       = 1'b0;
      node_waddr    = IW'(pool_count_ff);
      node_wdata    = '0;
      node_raddr    = req_data.node_index[IW-1:0];
      par_we        = 1'b0;
      par_waddr     = IW'(pool_count_ff);
      par_wdata     = '0;
      par_raddr     = req_data.node_index[IW-1:0];
      heap_we       = 1'b0;
      heap_waddr    = idx_ff;
      heap_wdata    = x_ff;
      heap_raddr    = l_pos[SIW-1:0];
      best_f        = x_ff[FREQ_BITS-1:0];
      sel           = 2'd0;
      sink_end      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               unique case (req_data.kind)
                  KIND_LOAD: begin
                     if (32'(req_data.symbol) < SYMBOLS) begin
                        freq_we = 1'b1;
                        fv_in[req_data.symbol[SAW-1:0]] = 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  KIND_BUILD: begin
                     pool_count_in = '0;
                     scan_in       = '0;
                     state_in      = S_SCAN_RD;
                  end
                  KIND_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_WR;
         end
         S_SCAN_WR: begin
            if (take) begin
               node_we    = 1'b1;
               node_wdata = {scan_f, 8'(scan_ff), {IW{1'b0}}, {IW{1'b0}}};
               par_we     = 1'b1;
               heap_we    = 1'b1;
               heap_waddr = SIW'(pool_count_ff);
               heap_wdata = {IW'(pool_count_ff), scan_f};
            end
            pool_count_in = n_next;
            if (scan_ff == SAW'(SYMBOLS - 1)) begin
               heap_count_in = HW'(n_next);
               leaf_count_in = n_next;
               if (n_next == '0) begin
                  state_in = S_RESP;
               end else begin
                  hi_in      = SIW'((n_next - PW'(1)) >> 1);
                  heapify_in = 1'b1;
                  state_in   = S_HY_LD;
               end
            end else begin
               scan_in  = scan_ff + SAW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_HY_LD: begin
            heap_raddr = hi_ff;
            state_in   = S_HY_X;
         end
         S_HY_X: begin
            x_in     = heap_rdata;
            idx_in   = hi_ff;
            state_in = S_SK_L;
         end
         S_SK_L: begin
            heap_raddr = l_pos[SIW-1:0];
            state_in   = S_SK_R;
         end
         S_SK_R: begin
            lw_in      = heap_rdata;
            heap_raddr = r_pos[SIW-1:0];
            state_in   = S_SK_C;
         end
         S_SK_C: begin
            if (l_ok && (lw_ff[FREQ_BITS-1:0] < best_f)) begin
               sel    = 2'd1;
               best_f = lw_ff[FREQ_BITS-1:0];
            end
            if (r_ok && (heap_rdata[FREQ_BITS-1:0] < best_f)) begin
               sel = 2'd2;
            end
            heap_we = 1'b1;
            case (sel)
               2'd1: begin
                  heap_wdata = lw_ff;
                  idx_in     = l_pos[SIW-1:0];
                  state_in   = S_SK_L;
               end
               2'd2: begin
                  heap_wdata = heap_rdata;
                  idx_in     = r_pos[SIW-1:0];
                  state_in   = S_SK_L;
               end
               default: begin
                  heap_wdata = x_ff;
                  sink_end   = 1'b1;
               end
            endcase
            if (sink_end) begin
               if (heapify_ff) begin
                  if (hi_ff == '0) begin
                     state_in = S_LOOP;
                  end else begin
                     hi_in    = hi_ff - SIW'(1);
                     state_in = S_HY_LD;
                  end
               end else if (!second_ff) begin
                  a_in      = top_ff;
                  second_in = 1'b1;
                  state_in  = S_POP_RD0;
               end else begin
                  state_in = S_MRG0;
               end
            end
         end
         S_LOOP: begin
            heapify_in = 1'b0;
            second_in  = 1'b0;
            if (heap_count_ff > HW'(1)) begin
               state_in = S_POP_RD0;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_RD0: begin
            heap_raddr = '0;
            state_in   = S_POP_RDL;
         end
         S_POP_RDL: begin
            top_in     = heap_rdata;
            heap_raddr = SIW'(heap_count_ff - HW'(1));
            state_in   = S_POP_SET;
         end
         S_POP_SET: begin
            x_in          = heap_rdata;
            heap_count_in = heap_count_ff - HW'(1);
            idx_in        = '0;
            state_in      = S_SK_L;
         end
         S_MRG0: begin
            if (pool_count_ff >= PW'(NODE_POOL)) begin
               state_in = S_LOOP;
            end else begin
               node_we    = 1'b1;
               node_wdata = {sum_s, 8'd0, a_ff[HWD-1:FREQ_BITS], top_ff[HWD-1:FREQ_BITS]};
               par_we     = 1'b1;
               x_in       = {IW'(pool_count_ff), sum_s};
               state_in   = S_MRG1;
            end
         end
         S_MRG1: begin
            par_we    = 1'b1;
            par_waddr = a_ff[HWD-1:FREQ_BITS];
            par_wdata = {1'b1, IW'(pool_count_ff)};
            state_in  = S_MRG2;
         end
         S_MRG2: begin
            par_we        = 1'b1;
            par_waddr     = top_ff[HWD-1:FREQ_BITS];
            par_wdata     = {1'b1, IW'(pool_count_ff)};
            pool_count_in = pool_count_ff + PW'(1);
            idx_in        = SIW'(heap_count_ff);
            heap_count_in = heap_count_ff + HW'(1);
            state_in      = S_RISE_CHK;
         end
         S_RISE_CHK: begin
            heap_raddr = p_pos;
            if (idx_ff == '0) begin
               heap_we  = 1'b1;
               state_in = S_LOOP;
            end else begin
               state_in = S_RISE_CMP;
            end
         end
         S_RISE_CMP: begin
            heap_we = 1'b1;
            if (heap_rdata[FREQ_BITS-1:0] > x_ff[FREQ_BITS-1:0]) begin
               heap_wdata = heap_rdata;
               idx_in     = p_pos;
               state_in   = S_RISE_CHK;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_READ: begin
            if ({1'b0, req_ff.node_index} < 10'(pool_count_ff)) begin
               res_in.node_freq = 32'(node_rdata[NW-1 -: FREQ_BITS]);
               res_in.is_leaf   = {1'b0, req_ff.node_index} < 10'(leaf_count_ff);
               if (res_in.is_leaf) begin
                  res_in.node_symbol = node_rdata[2*IW +: 8];
               end else begin
                  res_in.left_child  = 9'(node_rdata[IW +: IW]);
                  res_in.right_child = 9'(node_rdata[IW-1:0]);
               end
               res_in.has_parent = par_rdata[IW];
               if (par_rdata[IW]) begin
                  res_in.parent_node = 9'(par_rdata[IW-1:0]);
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in            = res_ff;
               rsp_in.node_count = 9'(pool_count_ff);
               rsp_in.tree_empty = (pool_count_ff == '0);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_count_ff <= '0;
         leaf_count_ff <= '0;
         heap_count_ff <= '0;
         second_ff     <= 1'b0;
         heapify_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fv_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         pool_count_ff <= pool_count_in;
         leaf_count_ff <= leaf_count_in;
         heap_count_ff <= heap_count_in;
         second_ff     <= second_in;
         heapify_ff    <= heapify_in;
         rsp_valid_ff  <= rsp_valid_in;
         fv_ff         <= fv_in;
      end
      scan_ff <= scan_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      lw_ff   <= lw_in;
      top_ff  <= top_in;
      a_ff    <= a_in;
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      heap_count_ff <= HW'(SYMBOLS))
      else $error("heap count exceeds symbol count");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_count_ff <= PW'(NODE_POOL))
      else $error("pool count exceeds pool size");

   a_leaf_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (leaf_count_ff <= pool_count_ff))
      else $error("more leaves than nodes after build");

   a_rise_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RISE_CMP) |-> (idx_ff != '0))
      else $error("sift-up compared past the root");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the code tree builder: loads symbol weights, runs
// builds and reads back every node, comparing each result word against a
// behavioral min-heap predictor, with random idling on both channels outside quiet mode.
// ----------------------------------------------------------------------------
module tb_top;
   import hbld_pkg::*;

   localparam int NSYM = 256;
   localparam int NPOOL = 512;
   localparam int WATCHDOG_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   huffman_tree_builder_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state.
   logic [31:0] weights [NSYM];
   logic [31:0] nd_freq [NPOOL];
   logic [7:0]  nd_sym [NPOOL];
   logic [8:0]  nd_left [NPOOL];
   logic [8:0]  nd_right [NPOOL];
   logic [8:0]  nd_par [NPOOL];
   logic        nd_haspar [NPOOL];
   int          heap [NPOOL];
   int          heap_n, node_n, leaf_n;

   rsp_type expected_words [$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  words_sent = 0, words_seen = 0, builds_done = 0;
   bit  quiet = 1'b0;

   function automatic void heap_sink(int idx);
      int best, l, r, t;
      forever begin
         best = idx;
         l = 2 * idx + 1;
         r = 2 * idx + 2;
         if (l < heap_n && nd_freq[heap[l]] < nd_freq[heap[best]]) best = l;
         if (r < heap_n && nd_freq[heap[r]] < nd_freq[heap[best]]) best = r;
         if (best == idx) return;
         t = heap[best]; heap[best] = heap[idx]; heap[idx] = t;
         idx = best;
      end
   endfunction

   function automatic int heap_pop();
      int top;
      top = heap[0];
      heap[0] = heap[heap_n - 1];
      heap_n--;
      heap_sink(0);
      return top;
   endfunction

   function automatic void tree_build();
      int a, b, i, p, t;
      logic [32:0] s;
      node_n = 0;
      for (int k = 0; k < NSYM; k++) begin
         if (weights[k] != 0) begin
            nd_freq[node_n] = weights[k];
            nd_sym[node_n] = k[7:0];
            nd_left[node_n] = '0;
            nd_right[node_n] = '0;
            nd_haspar[node_n] = 1'b0;
            nd_par[node_n] = '0;
            heap[node_n] = node_n;
            node_n++;
         end
      end
      heap_n = node_n;
      leaf_n = node_n;
      if (node_n > 0) begin
         i = (node_n - 1) / 2 + 1;
         while (i > 0) begin
            i--;
            heap_sink(i);
         end
      end
      while (heap_n > 1) begin
         a = heap_pop();
         b = heap_pop();
         if (node_n < NPOOL) begin
            s = {1'b0, nd_freq[a]} + {1'b0, nd_freq[b]};
            nd_freq[node_n] = s[32] ? 32'hFFFF_FFFF : s[31:0];
            nd_sym[node_n] = '0;
            nd_left[node_n] = a[8:0];
            nd_right[node_n] = b[8:0];
            nd_haspar[node_n] = 1'b0;
            nd_par[node_n] = '0;
            nd_haspar[a] = 1'b1; nd_par[a] = node_n[8:0];
            nd_haspar[b] = 1'b1; nd_par[b] = node_n[8:0];
            heap[heap_n] = node_n;
            node_n++;
            heap_n++;
            i = heap_n - 1;
            while (i > 0 && nd_freq[heap[(i - 1) / 2]] > nd_freq[heap[i]]) begin
               p = (i - 1) / 2;
               t = heap[i]; heap[i] = heap[p]; heap[p] = t;
               i = p;
            end
         end
      end
   endfunction

   function automatic rsp_type tree_respond(req_type r);
      rsp_type o;
      int idx;
      bit leaf;
      o = '0;
      idx = r.node_index;
      if (r.kind == KIND_LOAD) begin
         weights[r.symbol] = r.freq_value;
      end else if (r.kind == KIND_BUILD) begin
         tree_build();
      end else if (r.kind == KIND_READ && idx < node_n) begin
         leaf = idx < leaf_n;
         o.node_freq = nd_freq[idx];
         o.node_symbol = leaf ? nd_sym[idx] : 8'd0;
         o.left_child = leaf ? 9'd0 : nd_left[idx];
         o.right_child = leaf ? 9'd0 : nd_right[idx];
         o.parent_node = nd_haspar[idx] ? nd_par[idx] : 9'd0;
         o.is_leaf = leaf;
         o.has_parent = nd_haspar[idx];
      end
      o.node_count = node_n[8:0];
      o.tree_empty = (node_n == 0);
      return o;
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] sym,
                            input logic [31:0] val, input logic [8:0] idx);
      req_type r;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.kind = kind; r.symbol = sym; r.freq_value = val; r.node_index = idx;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(tree_respond(r));
      words_sent++;
   endtask

   task automatic read_all_nodes();
      int n;
      n = node_n;
      for (int k = 0; k < n; k++) send_word(KIND_READ, '0, '0, k[8:0]);
   endtask

   task automatic build_and_read();
      send_word(KIND_BUILD, '0, '0, '0);
      builds_done++;
      read_all_nodes();
   endtask

   task automatic clear_weights();
      for (int k = 0; k < NSYM; k++)
         if (weights[k] != 0) send_word(KIND_LOAD, k[7:0], '0, '0);
   endtask

   task automatic test_empty_tree();
      send_word(KIND_READ, '0, '0, 9'd0);
      send_word(KIND_BUILD, '0, '0, '0);
      send_word(KIND_READ, '0, '0, 9'h1FF);
      send_word(2'd3, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
   endtask

   task automatic test_single_and_saturation();
      send_word(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, '0);
      build_and_read();
      send_word(KIND_LOAD, 8'd255, 32'hFFFF_FFFF, '0);
      send_word(KIND_LOAD, 8'd128, 32'd1, '0);
      build_and_read();
      send_word(KIND_READ, '0, '0, 9'h1FF);
      clear_weights();
   endtask

   task automatic test_ties();
      for (int k = 0; k < 5; k++) send_word(KIND_LOAD, k[7:0] * 8'd37, 32'd7, '0);
      build_and_read();
      clear_weights();
   endtask

   task automatic test_large_weights();
      for (int k = 0; k < 8; k++)
         send_word(KIND_LOAD, 8'(k * 32 + 31), $urandom_range(0, 1) == 0 ? $urandom :
                   32'hFFFF_FFF0, '0);
      build_and_read();
   endtask

   task automatic test_random_trees();
      int nsym;
      logic [31:0] v;
      for (int t = 0; t < 2; t++) begin
         if (t == 1) quiet = 1'b1;
         nsym = $urandom_range(2, 6);
         for (int k = 0; k < nsym; k++) begin
            case ($urandom_range(0, 3))
               0: v = $urandom;
               1: v = 32'($urandom_range(0, 3));
               default: v = 32'($urandom_range(1, 100));
            endcase
            send_word(KIND_LOAD, 8'($urandom), v, '0);
         end
         build_and_read();
         for (int k = 0; k < 4; k++)
            send_word(2'($urandom), 8'($urandom), $urandom, 9'($urandom));
         if (node_n > 0) send_word(KIND_READ, '0, '0, 9'($urandom_range(0, node_n - 1)));
         clear_weights();
      end
   endtask

   // Result side: random stalls plus field-by-field comparison.
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (!reset && !quiet && rsp_ready && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = expected_words.pop_front();
            check_field("node_freq", e.node_freq, rsp_data.node_freq);
            check_field("node_symbol", e.node_symbol, rsp_data.node_symbol);
            check_field("left_child", e.left_child, rsp_data.left_child);
            check_field("right_child", e.right_child, rsp_data.right_child);
            check_field("parent_node", e.parent_node, rsp_data.parent_node);
            check_field("is_leaf", e.is_leaf, rsp_data.is_leaf);
            check_field("has_parent", e.has_parent, rsp_data.has_parent);
            check_field("node_count", e.node_count, rsp_data.node_count);
            check_field("tree_empty", e.tree_empty, rsp_data.tree_empty);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NSYM; k++) weights[k] = '0;
      heap_n = 0; node_n = 0; leaf_n = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tree();
      test_single_and_saturation();
      test_ties();
      test_random_trees();
      test_large_weights();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d request words, %0d builds, %0d result words checked.",
               words_sent, builds_done, words_seen);
      if (errors == 0 && expected_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
